// ----- hdl/mesp_pkg.sv -----
// Shared types, codes and result builders for the music event stream parser.
package mesp_pkg;

    localparam int DELAY_WIDTH_DEF = 24;
    localparam int DELAY_MS_W      = 24;
    localparam int FIFO_DEPTH      = 4;

    localparam logic [1:0] KIND_DELAY = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] CH_NONE = 8'hFF;

    typedef struct packed {
        logic [1:0]            kind;
        logic [3:0]            opcode_nibble;
        logic [7:0]            channel;
        logic [DELAY_MS_W-1:0] delay_ms;
        logic [7:0]            payload_first;
        logic [7:0]            payload_second;
        logic [7:0]            payload_third;
        logic [1:0]            payload_count;
        logic                  last_of_run;
    } t_result;

    // Up to two results produced by one input byte, in output order.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic t_result mk_delay(input logic [DELAY_MS_W-1:0] delay);
        t_result r;
        r                = '0;
        r.kind           = KIND_DELAY;
        r.channel        = CH_NONE;
        r.delay_ms       = delay;
        return r;
    endfunction

    function automatic t_result mk_event(input logic [3:0] op, input logic [7:0] ch,
                                         input logic [7:0] p0, input logic [7:0] p1,
                                         input logic [7:0] p2, input logic [1:0] cnt);
        t_result r;
        r                = '0;
        r.kind           = KIND_EVENT;
        r.opcode_nibble  = op;
        r.channel        = ch;
        r.payload_first  = p0;
        r.payload_second = p1;
        r.payload_third  = p2;
        r.payload_count  = cnt;
        return r;
    endfunction

    function automatic t_result mk_error();
        t_result r;
        r      = '0;
        r.kind = KIND_ERROR;
        return r;
    endfunction

endpackage

// ----- hdl/mesp_core.sv -----
// Input register, parse state and per-byte decode of the event stream.
module mesp_core #(
    parameter int DELAY_WIDTH = mesp_pkg::DELAY_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_end,
    input  logic                i_room,
    output mesp_pkg::t_push     o_push
);

    localparam logic [1:0] PH_LEAD    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_SKIP    = 2'd2;

    localparam logic [3:0] NIB_8 = 4'h8;
    localparam logic [3:0] NIB_9 = 4'h9;
    localparam logic [3:0] NIB_A = 4'hA;
    localparam logic [3:0] NIB_E = 4'hE;
    localparam logic [3:0] NIB_F = 4'hF;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_end;
    logic                   adv;

    logic [1:0]             r_phase, n_phase;
    logic [DELAY_WIDTH-1:0] r_delay_sum, n_delay_sum;
    logic                   r_pending, n_pending;
    logic [3:0]             r_opcode, n_opcode;
    logic [3:0]             r_channel, n_channel;
    logic [1:0]             r_needed, n_needed;
    logic [1:0]             r_held, n_held;
    logic [7:0]             r_store [2];
    logic [7:0]             n_store [2];

    assign adv     = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_byte;
            r_in_end  <= i_end;
        end
    end

    always_comb begin
        mesp_pkg::t_result      res [2];
        logic [1:0]             k;
        logic [1:0]             need;
        logic [2:0]             held_inc;
        logic [12:0]            add;
        logic [DELAY_WIDTH:0]   sum_wide;
        logic [31:0]            sum_ext;
        logic [3:0]             op;

        n_phase     = r_phase;
        n_delay_sum = r_delay_sum;
        n_pending   = r_pending;
        n_opcode    = r_opcode;
        n_channel   = r_channel;
        n_needed    = r_needed;
        n_held      = r_held;
        n_store     = r_store;
        res[0]      = '0;
        res[1]      = '0;
        k           = 2'd0;
        need        = (r_needed != 2'd0) ? r_needed : 2'd2;
        held_inc    = {1'b0, r_held} + 3'd1;
        add         = r_in_byte[6] ? {({1'b0, r_in_byte[5:0]} + 7'd1), 6'd0}
                                   : {6'd0, r_in_byte[6:0]};
        sum_wide    = {1'b0, r_delay_sum} + (DELAY_WIDTH+1)'(add);
        sum_ext     = '0;
        op          = r_in_byte[7:4];

        unique case (r_phase)
            PH_SKIP: begin
            end
            PH_PAYLOAD: begin
                if (held_inc >= {1'b0, need}) begin
                    if (need == 2'd3) begin
                        res[k[0]] = mesp_pkg::mk_event(r_opcode, {4'd0, r_channel},
                                        r_store[0], r_store[1], r_in_byte, need);
                    end else begin
                        res[k[0]] = mesp_pkg::mk_event(r_opcode, {4'd0, r_channel},
                                        r_store[0], r_in_byte, 8'd0, need);
                    end
                    k        = k + 2'd1;
                    n_phase  = PH_LEAD;
                    n_held   = 2'd0;
                    n_needed = 2'd0;
                end else begin
                    n_store[r_held[0]] = r_in_byte;
                    n_held             = held_inc[1:0];
                    if (r_in_end) begin
                        res[k[0]] = mesp_pkg::mk_error();
                        k         = k + 2'd1;
                        n_phase   = PH_SKIP;
                    end
                end
            end
            default: begin
                if (!r_in_byte[7]) begin
                    n_delay_sum = sum_wide[DELAY_WIDTH] ? '1 : sum_wide[DELAY_WIDTH-1:0];
                    n_pending   = 1'b1;
                end else begin
                    // Any pending delay goes out ahead of the lead's own result.
                    if (r_pending) begin
                        sum_ext     = 32'(r_delay_sum);
                        res[k[0]]   = mesp_pkg::mk_delay(sum_ext[mesp_pkg::DELAY_MS_W-1:0]);
                        k           = k + 2'd1;
                        n_pending   = 1'b0;
                        n_delay_sum = '0;
                    end
                    if (op == NIB_8 || op == NIB_9 || op == NIB_E || op == NIB_A) begin
                        n_opcode  = op;
                        n_channel = r_in_byte[3:0];
                        n_needed  = (op == NIB_A) ? 2'd3 : 2'd2;
                        n_held    = 2'd0;
                        n_phase   = PH_PAYLOAD;
                        if (r_in_end) begin
                            res[k[0]] = mesp_pkg::mk_error();
                            k         = k + 2'd1;
                            n_phase   = PH_SKIP;
                        end
                    end else if (op == NIB_F) begin
                        res[k[0]] = mesp_pkg::mk_event(op, mesp_pkg::CH_NONE,
                                        {4'd0, r_in_byte[3:0]}, 8'd0, 8'd0, 2'd1);
                        k         = k + 2'd1;
                    end else begin
                        res[k[0]] = mesp_pkg::mk_error();
                        k         = k + 2'd1;
                        n_phase   = PH_SKIP;
                    end
                end
            end
        endcase

        // Chunk end: flush what is still pending, then restart from reset state.
        if (r_in_end) begin
            if (n_phase != PH_SKIP && n_pending) begin
                sum_ext   = 32'(n_delay_sum);
                res[k[0]] = mesp_pkg::mk_delay(sum_ext[mesp_pkg::DELAY_MS_W-1:0]);
                k         = k + 2'd1;
            end
            n_phase     = PH_LEAD;
            n_delay_sum = '0;
            n_pending   = 1'b0;
            n_opcode    = 4'd0;
            n_channel   = 4'd0;
            n_needed    = 2'd0;
            n_held      = 2'd0;
        end

        if (k == 2'd2) begin
            res[1].last_of_run = 1'b1;
        end else if (k == 2'd1) begin
            res[0].last_of_run = 1'b1;
        end

        o_push.count = adv ? k : 2'd0;
        o_push.r0    = res[0];
        o_push.r1    = res[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_delay_sum <= '0;
            r_pending   <= 1'b0;
            r_opcode    <= 4'd0;
            r_channel   <= 4'd0;
            r_needed    <= 2'd0;
            r_held      <= 2'd0;
        end else if (adv) begin
            r_phase     <= n_phase;
            r_delay_sum <= n_delay_sum;
            r_pending   <= n_pending;
            r_opcode    <= n_opcode;
            r_channel   <= n_channel;
            r_needed    <= n_needed;
            r_held      <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_store <= n_store;
        end
    end

`ifndef SYNTHESIS
    // A lead byte always flushes the delay, so none can be pending mid-payload.
    a_no_delay_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> !r_pending)
        else $error("delay pending while collecting payload");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_end) |=> (r_phase == PH_LEAD && !r_pending && r_held == 2'd0))
        else $error("parse state not restored after chunk end");
`endif

endmodule

// ----- hdl/mesp_result_fifo.sv -----
// Four-entry result queue: takes up to two results a cycle, hands out one.
module mesp_result_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mesp_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output mesp_pkg::t_result   o_result
);

    localparam int PTR_W = $clog2(mesp_pkg::FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    mesp_pkg::t_result r_mem [mesp_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              pop;
    logic [PTR_W-1:0]  wr_ptr_1;

    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    assign o_room   = (r_count <= CNT_W'(mesp_pkg::FIFO_DEPTH - 2));
    assign wr_ptr_1 = r_wr_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_W'(i_push.count) - CNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> (r_count <= CNT_W'(mesp_pkg::FIFO_DEPTH - 2)))
        else $error("result pushed without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(mesp_pkg::FIFO_DEPTH))
        else $error("result queue count out of range");
`endif

endmodule

// ----- hdl/music_event_stream_parser.sv -----
// Top level of the music event stream parser: byte stream in, parsed results out.
//
// Takes an event chunk one byte per request on the slave side (tlast marks the
// chunk's final byte) and returns parsed results on the master side. Runs of
// delay bytes are summed (saturating at DELAY_WIDTH bits) into one delay
// result, flushed by the next lead byte or by the chunk end. Lead nibbles 8, 9
// and E carry two payload bytes, A carries three, F is reported at once with
// its low nibble as payload; B, C, D or a payload cut short by the chunk end
// give an error, after which the rest of the chunk is dropped. The state
// returns to its reset value after every chunk end. Timing: one byte is taken
// every cycle while the output side keeps up; a byte that causes two results
// (delay flush plus event or error) sends both out through the single result
// port, one after the other. A byte passes through the input register and
// then the four-entry result queue. The queue takes a new byte only while at
// least two entries are free, so the input side never waits on the output
// side's ready in the same cycle.
module music_event_stream_parser #(
    parameter int DELAY_WIDTH = mesp_pkg::DELAY_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // chunk_end
    // Results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [3:0] opcode_nibble, [11:4] channel,
                                        // [35:12] delay_ms, [43:36] payload_first,
                                        // [51:44] payload_second, [59:52] payload_third,
                                        // [61:60] payload_count, [63:62] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last_of_run
);

    mesp_pkg::t_push   push;
    mesp_pkg::t_result result;
    logic              room;

    mesp_core #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_end   (s_axis_tlast),
        .i_room  (room),
        .o_push  (push)
    );

    mesp_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // Pack result fields from the lowest bit up.
    assign m_axis_tdata = {2'b00,
                           result.payload_count,
                           result.payload_third,
                           result.payload_second,
                           result.payload_first,
                           result.delay_ms,
                           result.channel,
                           result.opcode_nibble};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last_of_run;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the music event stream parser: byte requests in, results out.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW             = mesp_pkg::DELAY_WIDTH_DEF;
    localparam int LATENCY_CYCLES = 4;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_IDLE       = 17;
    localparam int RANDOM_ITEMS   = 750;

    // Lead-byte high nibbles
    localparam logic [3:0] OP_TWO_8   = 4'h8;
    localparam logic [3:0] OP_TWO_9   = 4'h9;
    localparam logic [3:0] OP_THREE_A = 4'hA;
    localparam logic [3:0] OP_BAD_B   = 4'hB;
    localparam logic [3:0] OP_BAD_C   = 4'hC;
    localparam logic [3:0] OP_BAD_D   = 4'hD;
    localparam logic [3:0] OP_TWO_E   = 4'hE;
    localparam logic [3:0] OP_SHORT_F = 4'hF;

    typedef enum logic [1:0] {
        PH_LEAD    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_SKIP    = 2'd2
    } t_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] data_byte
    logic        s_axis_tlast;     // chunk_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;     // [3:0] opcode, [11:4] channel, [35:12] delay_ms,
                                   // [43:36] p0, [51:44] p1, [59:52] p2, [61:60] count
    logic [1:0]  m_axis_tuser;     // [1:0] kind
    logic        m_axis_tlast;     // last_of_run

    // Parser mirror
    t_phase      pp_phase;
    logic [DW-1:0] pp_sum;
    logic        pp_pending;
    logic [3:0]  pp_op;
    logic [3:0]  pp_ch;
    logic [1:0]  pp_need;
    logic [1:0]  pp_held;
    logic [7:0]  pp_store [2];

    mesp_pkg::t_result due_results[$];   // parsed results still to come out, oldest first
    mesp_pkg::t_result step_out[$];      // results of the byte being parsed
    logic [7:0]  chunk_bytes[$];   // chunk being built for sending

    int          error_count = 0;
    int          bytes_sent  = 0;
    int          cycle_count;
    bit          no_idle     = 1'b0;

    music_event_stream_parser #(
        .DELAY_WIDTH(DW)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- parser mirror

    task automatic clear_parser();
        pp_phase    = PH_LEAD;
        pp_sum      = '0;
        pp_pending  = 1'b0;
        pp_op       = '0;
        pp_ch       = '0;
        pp_need     = '0;
        pp_held     = '0;
        pp_store[0] = '0;
        pp_store[1] = '0;
    endtask

    task automatic emit_delay();
        mesp_pkg::t_result r;
        if (pp_pending) begin
            r          = '0;
            r.kind     = mesp_pkg::KIND_DELAY;
            r.channel  = mesp_pkg::CH_NONE;
            r.delay_ms = mesp_pkg::DELAY_MS_W'(pp_sum);
            step_out.push_back(r);
            pp_pending = 1'b0;
            pp_sum     = '0;
        end
    endtask

    task automatic emit_error();
        mesp_pkg::t_result r;
        r        = '0;
        r.kind   = mesp_pkg::KIND_ERROR;
        step_out.push_back(r);
        pp_phase = PH_SKIP;
    endtask

    // Works out the results of one accepted byte and queues them.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        mesp_pkg::t_result r;
        logic [1:0]  need;
        logic [12:0] add;
        logic [DW:0] grown;
        step_out.delete();
        r = '0;
        case (pp_phase)
            PH_SKIP: ;  // rest of a broken chunk is dropped
            PH_PAYLOAD: begin
                need = (pp_need != 2'd0) ? pp_need : 2'd2;
                if (3'(pp_held) + 3'd1 >= 3'(need)) begin
                    r.kind           = mesp_pkg::KIND_EVENT;
                    r.opcode_nibble  = pp_op;
                    r.channel        = {4'h0, pp_ch};
                    r.payload_first  = pp_store[0];
                    r.payload_second = (need == 2'd3) ? pp_store[1] : b;
                    r.payload_third  = (need == 2'd3) ? b : 8'h00;
                    r.payload_count  = need;
                    step_out.push_back(r);
                    pp_phase = PH_LEAD;
                    pp_held  = '0;
                    pp_need  = '0;
                end else begin
                    pp_store[pp_held[0]] = b;
                    pp_held++;
                    if (last) begin
                        emit_error();  // payload cut short
                    end
                end
            end
            default: begin  // expecting a lead byte; spare code acts the same
                if (!b[7]) begin
                    add   = b[6] ? ({7'd0, b[5:0]} + 13'd1) << 6 : {5'd0, b};
                    grown = {1'b0, pp_sum} + (DW+1)'(add);
                    pp_sum     = grown[DW] ? '1 : grown[DW-1:0];
                    pp_pending = 1'b1;
                end else begin
                    emit_delay();
                    case (b[7:4])
                        OP_TWO_8, OP_TWO_9, OP_TWO_E, OP_THREE_A: begin
                            pp_op    = b[7:4];
                            pp_ch    = b[3:0];
                            pp_need  = (b[7:4] == OP_THREE_A) ? 2'd3 : 2'd2;
                            pp_held  = '0;
                            pp_phase = PH_PAYLOAD;
                            if (last) begin
                                emit_error();  // lead alone at chunk end
                            end
                        end
                        OP_SHORT_F: begin
                            r.kind          = mesp_pkg::KIND_EVENT;
                            r.opcode_nibble = OP_SHORT_F;
                            r.channel       = mesp_pkg::CH_NONE;
                            r.payload_first = {4'h0, b[3:0]};
                            r.payload_count = 2'd1;
                            step_out.push_back(r);
                        end
                        default: emit_error();
                    endcase
                end
            end
        endcase
        if (last) begin
            if (pp_phase != PH_SKIP) begin
                emit_delay();
            end
            clear_parser();
        end
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last_of_run = 1'b1;
            step_out.push_back(r);
        end
        foreach (step_out[i]) begin
            due_results.push_back(step_out[i]);
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Input requests feed the mirror first, then the result of this edge is checked.
    always @(posedge i_clk) begin : result_checker
        mesp_pkg::t_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with none due, kind", 32'(m_axis_tuser), 32'd0);
                end else begin
                    want = due_results.pop_front();
                    check_field("kind",           m_axis_tuser,         want.kind);
                    check_field("opcode_nibble",  m_axis_tdata[3:0],    want.opcode_nibble);
                    check_field("channel",        m_axis_tdata[11:4],   want.channel);
                    check_field("delay_ms",       m_axis_tdata[35:12],  want.delay_ms);
                    check_field("payload_first",  m_axis_tdata[43:36],  want.payload_first);
                    check_field("payload_second", m_axis_tdata[51:44],  want.payload_second);
                    check_field("payload_third",  m_axis_tdata[59:52],  want.payload_third);
                    check_field("payload_count",  m_axis_tdata[61:60],  want.payload_count);
                    check_field("pad",            m_axis_tdata[63:62],  32'd0);
                    check_field("last_of_run",    m_axis_tlast,         want.last_of_run);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic int draw_idle();
        if (no_idle || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // Result side: a fresh stall draw for every result taken.
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_idle();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // One byte request; valid stays up into the next request when no gap is drawn.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_chunk();
        foreach (chunk_bytes[i]) begin
            send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
        end
        chunk_bytes.delete();
    endtask

    // Sender holds off until every queued result is out and the pipe is empty.
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0);
        repeat (LATENCY_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_lead(input logic [3:0] op, input int n_payload);
        chunk_bytes.push_back({op, 4'($urandom)});
        repeat (n_payload) chunk_bytes.push_back(8'($urandom));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_delay_bytes();
        // zero delay still reported at chunk end
        chunk_bytes = '{8'h00};
        send_chunk();
        // short max, long min, long max, flushed by an F lead, then a tail delay
        chunk_bytes = '{8'h3F, 8'h40, 8'h7F, 8'h01, 8'hF3, 8'h12};
        send_chunk();
    endtask

    task automatic test_channel_events();
        chunk_bytes = '{8'h80, 8'h00, 8'hFF, 8'h9F, 8'h80, 8'h7F,
                        8'hA3, 8'hFF, 8'h81, 8'hC0, 8'hF0, 8'hFF};
        send_chunk();
        // E event whose last payload byte ends the chunk: no error
        chunk_bytes = '{8'hE5, 8'hAA, 8'h55};
        send_chunk();
    endtask

    task automatic test_malformed();
        // bad lead, rest of chunk dropped
        chunk_bytes = '{8'hB0, 8'h90, 8'h12};
        send_chunk();
        // delay flush plus error on one byte
        chunk_bytes = '{8'h05, 8'hC1, 8'h7F};
        send_chunk();
        chunk_bytes = '{8'hDF};
        send_chunk();
        // three-byte payload cut short after two
        chunk_bytes = '{8'hA1, 8'h01, 8'h02};
        send_chunk();
        // lead needing payload ends the chunk after a delay
        chunk_bytes = '{8'h10, 8'h9E};
        send_chunk();
        // F lead ends the chunk after a delay: two results
        chunk_bytes = '{8'h30, 8'hF7};
        send_chunk();
    endtask

    task automatic build_random_chunk();
        int         parts;
        int         sel;
        logic [3:0] two_ops [3] = '{OP_TWO_8, OP_TWO_9, OP_TWO_E};
        parts = $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0) begin
            // raw noise chunk
            repeat ($urandom_range(1, 8)) chunk_bytes.push_back(8'($urandom));
            return;
        end
        for (int p = 0; p < parts; p++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                repeat ($urandom_range(1, 4)) chunk_bytes.push_back({1'b0, 7'($urandom)});
            end else if (sel < 55) begin
                push_lead(two_ops[$urandom_range(0, 2)], 2);
            end else if (sel < 70) begin
                push_lead(OP_THREE_A, 3);
            end else if (sel < 80) begin
                push_lead(OP_SHORT_F, 0);
            end else if (sel < 86) begin
                push_lead(OP_BAD_B + 4'($urandom_range(0, 2)), $urandom_range(0, 3));
            end else if (sel < 94) begin
                // payload cut short by the chunk end
                if ($urandom_range(0, 1) == 0) begin
                    push_lead(OP_THREE_A, $urandom_range(0, 2));
                end else begin
                    push_lead(two_ops[$urandom_range(0, 2)], $urandom_range(0, 1));
                end
                break;
            end else begin
                repeat ($urandom_range(1, 4)) chunk_bytes.push_back(8'($urandom));
            end
        end
    endtask

    task automatic test_random_chunks();
        int stop_at;
        stop_at = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < stop_at) begin
            no_idle = ($urandom_range(0, 5) == 0);
            build_random_chunk();
            send_chunk();
            if ($urandom_range(0, 15) == 0) begin
                wait_results_done();
            end
        end
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------- run control

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        clear_parser();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_delay_bytes();
        wait_results_done();
        test_channel_events();
        wait_results_done();
        test_malformed();
        wait_results_done();
        test_random_chunks();
        wait_results_done();

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
